// File: rtl/ffe_pkg.sv
// Shared types, constants and register codes for the flip-flop EWMA estimator.
`default_nettype none
package ffe_pkg;

  localparam int OBS_W          = 32;
  localparam int EST_W          = 32;
  localparam int GAIN_W         = 16;
  localparam int KW             = GAIN_W + 1;
  localparam int CHUNK_W        = 16;
  localparam int LF_FRAC        = 12;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 16;
  localparam int VALUE_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  localparam logic [KW-1:0]     GAIN_ONE  = KW'(1) << GAIN_W;
  localparam logic [GAIN_W-1:0] GAIN_HALF = GAIN_W'(1) << (GAIN_W - 1);

  localparam logic [GAIN_W-1:0] FAST_GAIN_RST    = 16'd6554;
  localparam logic [GAIN_W-1:0] SLOW_GAIN_RST    = 16'd58982;
  localparam logic [GAIN_W-1:0] RANGE_GAIN_RST   = 16'd58982;
  localparam logic [GAIN_W-1:0] CENTER_GAIN_RST  = 16'd6554;
  localparam logic [GAIN_W-1:0] LIMIT_FACTOR_RST = 16'd10894;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FAST_GAIN    = 3'd0,
    CFG_SLOW_GAIN    = 3'd1,
    CFG_RANGE_GAIN   = 3'd2,
    CFG_CENTER_GAIN  = 3'd3,
    CFG_LIMIT_FACTOR = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [GAIN_W-1:0] fast_gain;
    logic [GAIN_W-1:0] slow_gain;
    logic [GAIN_W-1:0] range_gain;
    logic [GAIN_W-1:0] center_gain;
    logic [GAIN_W-1:0] limit_factor;
  } ffe_cfg_t;

  typedef struct packed {
    logic          start;
    logic [KW-1:0] k;
  } ffe_mac_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } ffe_mac_sts_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_AGILE,
    S_STABLE,
    S_CHK1,
    S_RANGE,
    S_CENTER,
    S_CHK2,
    S_EMIT
  } ffe_state_t;

endpackage
`default_nettype wire

// File: rtl/ffe_if.sv
// Observation and result channel interfaces.
`default_nettype none
interface ffe_in_if;
  import ffe_pkg::*;
  logic             valid;
  logic             ready;
  logic [OBS_W-1:0] observation;
  logic             restart;
  modport source (output valid, output observation, output restart, input ready);
  modport sink (input valid, input observation, input restart, output ready);
endinterface

interface ffe_out_if;
  import ffe_pkg::*;
  logic             valid;
  logic             ready;
  logic [EST_W-1:0] estimate;
  logic             within_limits;
  modport source (output valid, output estimate, output within_limits, input ready);
  modport sink (input valid, input estimate, input within_limits, output ready);
endinterface
`default_nettype wire

// File: rtl/ffe_cfg.sv
// Configuration register bank for the gains and the limit factor.
`default_nettype none
module ffe_cfg (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [ffe_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  wire logic [ffe_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output ffe_pkg::ffe_cfg_t                     cfg
);
  import ffe_pkg::*;

  ffe_cfg_t cfg_r;
  ffe_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_idx))
        CFG_FAST_GAIN:    cfg_nxt.fast_gain    = cfg_wdata;
        CFG_SLOW_GAIN:    cfg_nxt.slow_gain    = cfg_wdata;
        CFG_RANGE_GAIN:   cfg_nxt.range_gain   = cfg_wdata;
        CFG_CENTER_GAIN:  cfg_nxt.center_gain  = cfg_wdata;
        CFG_LIMIT_FACTOR: cfg_nxt.limit_factor = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fast_gain    <= FAST_GAIN_RST;
      cfg_r.slow_gain    <= SLOW_GAIN_RST;
      cfg_r.range_gain   <= RANGE_GAIN_RST;
      cfg_r.center_gain  <= CENTER_GAIN_RST;
      cfg_r.limit_factor <= LIMIT_FACTOR_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

// File: rtl/ffe_mac.sv
// Shared multiplier: 17 x 16 bits a cycle, accumulated top chunk first.
`default_nettype none
module ffe_mac #(
  parameter int W = ffe_pkg::VALUE_BITS_DEF + ffe_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  ffe_pkg::ffe_mac_ctl_t                      ctl,
  input  wire logic [W-1:0]                          m,
  output ffe_pkg::ffe_mac_sts_t                      sts,
  output logic [(W+15)/16*16+ffe_pkg::KW-1:0]        acc
);
  import ffe_pkg::*;

  localparam int CHUNKS = (W + CHUNK_W - 1) / CHUNK_W;
  localparam int MW     = CHUNKS * CHUNK_W;
  localparam int ACC_W  = MW + KW;
  localparam int CNT_W  = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;

  logic                    busy_r;
  logic                    done_r;
  logic [CNT_W-1:0]        cnt_r;
  logic [KW-1:0]           k_r;
  logic [MW-1:0]           m_r;
  logic [ACC_W-1:0]        acc_r;
  logic [KW+CHUNK_W-1:0]   pp;
  logic                    last;

  assign pp   = k_r * m_r[MW-1 -: CHUNK_W];
  assign last = (cnt_r == CNT_W'(CHUNKS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (ctl.start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r  <= cnt_r + CNT_W'(1);
      busy_r <= !last;
      done_r <= last;
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      k_r   <= ctl.k;
      m_r   <= MW'(m);
      acc_r <= '0;
    end else if (busy_r) begin
      acc_r <= (acc_r << CHUNK_W) + ACC_W'(pp);
      m_r   <= m_r << CHUNK_W;
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign acc      = acc_r;

endmodule
`default_nettype wire

// File: rtl/flip_flop_ewma_estimator_core.sv
// Top level of the flip-flop EWMA estimator: sequencer, state registers and result stage.
//
//  channel  | direction | transaction
//  ---------+-----------+----------------------------------------------
//  in_ch    | sink      | observation[31:0], restart
//  out_ch   | source    | estimate[31:0], within_limits
//  cfg_*    | write     | cfg_idx[2:0], cfg_wdata[15:0] on cfg_we
//
// A seeding observation (first after reset or with restart) goes straight to the hand-over
// state with no multiplier pass. Otherwise five or six blend/limit operations run, one after
// another, on the one shared multiplier. The input is ready only when the sequencer is idle;
// the result register is separate, so a new transaction is taken while a result waits, and a
// stalled result holds the sequencer only at the point of handing over the next one.
// Synchronous reset, no clearing pass.
`default_nettype none
module flip_flop_ewma_estimator_core #(
  parameter int VALUE_BITS = ffe_pkg::VALUE_BITS_DEF,
  parameter int FRAC_BITS  = ffe_pkg::FRAC_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  ffe_in_if.sink                               in_ch,
  ffe_out_if.source                            out_ch,
  input  wire logic                            cfg_we,
  input  wire logic [ffe_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  wire logic [ffe_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import ffe_pkg::*;

  localparam int W        = VALUE_BITS + FRAC_BITS;
  localparam int OBS_BITS = (VALUE_BITS < OBS_W) ? VALUE_BITS : OBS_W;
  localparam int CHUNKS   = (W + CHUNK_W - 1) / CHUNK_W;
  localparam int ACC_W    = CHUNKS * CHUNK_W + KW;
  localparam logic [W:0] EST_HALF = (W + 1)'(1) << (FRAC_BITS - 1);

  ffe_cfg_t      cfg;
  ffe_mac_ctl_t  mac_ctl;
  ffe_mac_sts_t  mac_sts;
  logic [ACC_W-1:0] acc;
  logic [W-1:0]  mac_m;
  logic          mac_start;
  logic [KW-1:0] mac_k;

  ffe_state_t    st_r, st_nxt;
  logic          seeded_r;
  logic          w_r;
  logic [OBS_BITS-1:0] last_r;
  logic [W-1:0]  spot_r, step_r, base_r;
  logic [W-1:0]  agile_r, stable_r, center_r, mr_r;
  logic          out_valid_r;
  logic [EST_W-1:0] est_r;
  logic          within_r;

  logic          in_acc, seed, emit_go;
  logic [OBS_BITS-1:0] in_obs, obs_diff;
  logic [W-1:0]  in_spot, in_step, spot_cur;
  logic [W-1:0]  op_old, op_spot, base_nxt, blend_res, diff;
  logic [GAIN_W-1:0] op_gain;
  logic          chk_op, op_ge, within_now;
  logic [ACC_W-1:0] rnd;
  logic [W-1:0]  chosen;
  logic [W:0]    est_full;

  ffe_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  ffe_mac #(.W(W)) u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mac_ctl),
    .m     (mac_m),
    .sts   (mac_sts),
    .acc   (acc)
  );

  assign mac_ctl = '{start: mac_start, k: mac_k};

  assign in_ch.ready = (st_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign seed        = in_ch.restart || !seeded_r;
  assign in_obs      = in_ch.observation[OBS_BITS-1:0];
  assign obs_diff    = (in_obs > last_r) ? in_obs - last_r : last_r - in_obs;
  assign in_spot     = W'(in_obs) << FRAC_BITS;
  assign in_step     = W'(obs_diff) << FRAC_BITS;
  assign spot_cur    = (st_r == S_IDLE) ? in_spot : spot_r;

  // blend finish and limit check, both on the accumulated product
  assign rnd        = acc + ACC_W'(GAIN_HALF);
  assign blend_res  = base_r + W'(rnd >> GAIN_W);
  assign diff       = (spot_r >= center_r) ? spot_r - center_r : center_r - spot_r;
  assign within_now = ACC_W'(diff) <= (acc >> LF_FRAC);
  assign emit_go    = (st_r == S_EMIT) && (!out_valid_r || out_ch.ready);

  always_comb begin
    st_nxt    = st_r;
    mac_start = 1'b0;
    unique case (st_r)
      S_IDLE: begin
        if (in_acc) begin
          if (seed) begin
            st_nxt = S_EMIT;
          end else begin
            st_nxt    = S_AGILE;
            mac_start = 1'b1;
          end
        end
      end
      S_AGILE: begin
        if (mac_sts.done) begin
          st_nxt    = S_STABLE;
          mac_start = 1'b1;
        end
      end
      S_STABLE: begin
        if (mac_sts.done) begin
          st_nxt    = S_CHK1;
          mac_start = 1'b1;
        end
      end
      S_CHK1: begin
        if (mac_sts.done) begin
          st_nxt    = within_now ? S_RANGE : S_CENTER;
          mac_start = 1'b1;
        end
      end
      S_RANGE: begin
        if (mac_sts.done) begin
          st_nxt    = S_CENTER;
          mac_start = 1'b1;
        end
      end
      S_CENTER: begin
        if (mac_sts.done) begin
          st_nxt    = S_CHK2;
          mac_start = 1'b1;
        end
      end
      S_CHK2: begin
        if (mac_sts.done) begin
          st_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (emit_go) begin
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  // operands of the operation about to start
  always_comb begin
    op_old  = agile_r;
    op_spot = spot_cur;
    op_gain = cfg.fast_gain;
    chk_op  = 1'b0;
    case (st_nxt) inside
      S_STABLE: begin
        op_old  = stable_r;
        op_gain = cfg.slow_gain;
      end
      S_RANGE: begin
        op_old  = mr_r;
        op_spot = step_r;
        op_gain = cfg.range_gain;
      end
      S_CENTER: begin
        op_old  = center_r;
        op_gain = cfg.center_gain;
      end
      S_CHK1, S_CHK2: chk_op = 1'b1;
      default: ;
    endcase
    op_ge = (op_old >= op_spot);
    if (chk_op) begin
      mac_k = {1'b0, cfg.limit_factor};
      mac_m = mr_r;
    end else if (op_ge) begin
      mac_k = {1'b0, op_gain};
      mac_m = op_old - op_spot;
    end else begin
      mac_k = GAIN_ONE - {1'b0, op_gain};
      mac_m = op_spot - op_old;
    end
    base_nxt = op_ge ? op_spot : op_old;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      seeded_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (in_acc) begin
        seeded_r <= 1'b1;
      end
      if (emit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mac_start) begin
      base_r <= base_nxt;
    end
    if (in_acc) begin
      spot_r <= in_spot;
      step_r <= in_step;
      last_r <= in_obs;
      if (seed) begin
        agile_r  <= in_spot;
        stable_r <= in_spot;
        center_r <= in_spot;
        mr_r     <= '0;
        w_r      <= 1'b1;
      end
    end
    if (mac_sts.done) begin
      case (st_r)
        S_AGILE:  agile_r  <= blend_res;
        S_STABLE: stable_r <= blend_res;
        S_RANGE:  mr_r     <= blend_res;
        S_CENTER: center_r <= blend_res;
        S_CHK2:   w_r      <= within_now;
        default: ;
      endcase
    end
    if (emit_go) begin
      est_r    <= EST_W'(est_full);
      within_r <= w_r;
    end
  end

  assign chosen   = w_r ? agile_r : stable_r;
  assign est_full = ({1'b0, chosen} + EST_HALF) >> FRAC_BITS;

  assign out_ch.valid         = out_valid_r;
  assign out_ch.estimate      = est_r;
  assign out_ch.within_limits = within_r;

  a_done_in_op: assert property (@(posedge clk) disable iff (!rst_n)
    mac_sts.done |-> (st_r != S_IDLE && st_r != S_EMIT))
    else $error("multiplier finished outside an operation");

  a_accept_mac_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> !mac_sts.busy)
    else $error("transaction taken while the multiplier is busy");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> st_r != S_IDLE)
    else $error("sequencer stayed idle after a transaction");

  a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(st_r) == S_EMIT)
    else $error("result raised outside the hand-over state");

  a_restart_seeds: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_ch.restart |=> seeded_r && w_r && st_r == S_EMIT)
    else $error("restart did not seed");

endmodule
`default_nettype wire

// File: bench/ffe_checker.sv
// Scoreboard for the flip-flop EWMA estimator: tracks register writes, predicts and compares results.
`timescale 1ns / 100ps
`default_nettype none
module ffe_checker (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  ffe_in_if                                   in_ch,
  ffe_out_if                                  out_ch,
  input  wire logic                           cfg_we,
  input  wire logic [ffe_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [ffe_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                                  fail_count,
  output int                                  outstanding
);
  import ffe_pkg::*;

  localparam int ACC_W = VALUE_BITS_DEF + FRAC_BITS_DEF;

  typedef logic [ACC_W-1:0] fix_t;

  localparam fix_t HALF_LSB = fix_t'(1) << (FRAC_BITS_DEF - 1);

  typedef struct packed {
    logic [EST_W-1:0] estimate;
    logic             within_limits;
  } est_t;

  typedef struct packed {
    logic [OBS_W-1:0] last_obs;
    fix_t             agile;
    fix_t             stable;
    fix_t             center;
    fix_t             mrange;
    logic             seeded;
  } ffe_track_t;

  ffe_cfg_t   regs;
  ffe_track_t trk;
  est_t       pending_estimates[$];
  int         fails = 0;

  // Exact round-half-up blend: g/65536 of the old value, the rest of the new one.
  function automatic fix_t ewma_blend(input fix_t old_v, input fix_t spot,
                                      input logic [GAIN_W-1:0] g);
    logic [ACC_W+KW:0] acc;
    acc = old_v * g + spot * (GAIN_ONE - g) + GAIN_HALF;
    return acc[ACC_W+GAIN_W-1:GAIN_W];
  endfunction

  function automatic logic in_band(input fix_t spot);
    fix_t                    dev;
    logic [ACC_W+GAIN_W-1:0] reach;
    dev   = (spot > trk.center) ? spot - trk.center : trk.center - spot;
    reach = (trk.mrange * regs.limit_factor) >> LF_FRAC;
    return dev <= reach;
  endfunction

  function automatic est_t next_estimate(input logic [OBS_W-1:0] obs, input logic rs);
    fix_t             spot;
    fix_t             jump;
    fix_t             pick;
    logic [OBS_W-1:0] delta;
    est_t             r;
    spot = fix_t'(obs) << FRAC_BITS_DEF;
    if (rs) begin
      trk = '0;
    end
    delta        = (obs > trk.last_obs) ? obs - trk.last_obs : trk.last_obs - obs;
    jump         = fix_t'(delta) << FRAC_BITS_DEF;
    trk.last_obs = obs;
    if (!trk.seeded) begin
      trk.agile  = spot;
      trk.stable = spot;
      trk.center = spot;
      trk.seeded = 1'b1;
    end else begin
      trk.agile  = ewma_blend(trk.agile, spot, regs.fast_gain);
      trk.stable = ewma_blend(trk.stable, spot, regs.slow_gain);
      // range only moves when the reading sits inside the old limits
      if (in_band(spot)) begin
        trk.mrange = ewma_blend(trk.mrange, jump, regs.range_gain);
      end
      trk.center = ewma_blend(trk.center, spot, regs.center_gain);
    end
    r.within_limits = in_band(spot);
    pick            = (r.within_limits ? trk.agile : trk.stable) + HALF_LSB;
    r.estimate      = pick[FRAC_BITS_DEF +: EST_W];
    return r;
  endfunction

  always @(posedge clk) begin
    est_t want;
    if (!rst_n) begin
      regs.fast_gain    = FAST_GAIN_RST;
      regs.slow_gain    = SLOW_GAIN_RST;
      regs.range_gain   = RANGE_GAIN_RST;
      regs.center_gain  = CENTER_GAIN_RST;
      regs.limit_factor = LIMIT_FACTOR_RST;
      trk               = '0;
      pending_estimates.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_FAST_GAIN:    regs.fast_gain    = cfg_wdata;
          CFG_SLOW_GAIN:    regs.slow_gain    = cfg_wdata;
          CFG_RANGE_GAIN:   regs.range_gain   = cfg_wdata;
          CFG_CENTER_GAIN:  regs.center_gain  = cfg_wdata;
          CFG_LIMIT_FACTOR: regs.limit_factor = cfg_wdata;
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        if (pending_estimates.size() == 0) begin
          fails++;
          $display("%0t: unexpected result transaction, expected none, got estimate %h within %b",
                   $time, out_ch.estimate, out_ch.within_limits);
        end else begin
          want = pending_estimates.pop_front();
          if (out_ch.estimate !== want.estimate) begin
            fails++;
            $display("%0t: estimate mismatch, expected %h, got %h",
                     $time, want.estimate, out_ch.estimate);
          end
          if (out_ch.within_limits !== want.within_limits) begin
            fails++;
            $display("%0t: within_limits mismatch, expected %b, got %b",
                     $time, want.within_limits, out_ch.within_limits);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        pending_estimates.push_back(next_estimate(in_ch.observation, in_ch.restart));
      end
    end
    fail_count  <= fails;
    outstanding <= pending_estimates.size();
  end

endmodule
`default_nettype wire

// File: bench/tb.sv
// Top-level testbench for the flip-flop EWMA estimator: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
`default_nettype none
module tb;
  import ffe_pkg::*;

  localparam int CYCLE_LIMIT     = 500000;
  localparam int DRAIN_CYCLES    = 40;
  localparam int HOLD_OFF_CYCLES = 400;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  hold_off    = 1'b0;
  int                    fail_count;
  int                    outstanding;
  int                    cycle_count = 0;
  int                    tx_idle_pct = 0;
  int                    rx_idle_pct = 0;
  event                  hold_off_ev;

  ffe_in_if  in_ch ();
  ffe_out_if out_ch ();

  flip_flop_ewma_estimator_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  ffe_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_we      (cfg_we),
    .cfg_idx     (cfg_idx),
    .cfg_wdata   (cfg_wdata),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= !hold_off && ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // long receiver stall so the block backs up onto its input
  initial begin
    forever begin
      @(hold_off_ev);
      hold_off <= 1'b1;
      repeat (HOLD_OFF_CYCLES) @(posedge clk);
      hold_off <= 1'b0;
    end
  end

  task automatic set_idling(input int tx_pct, input int rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct <= rx_pct;
  endtask

  task automatic send_obs(input logic [OBS_W-1:0] obs, input logic rs);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.observation <= obs;
    in_ch.restart     <= rs;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic load_regs(input logic [CFG_DATA_W-1:0] ag, input logic [CFG_DATA_W-1:0] st,
                           input logic [CFG_DATA_W-1:0] rg, input logic [CFG_DATA_W-1:0] ce,
                           input logic [CFG_DATA_W-1:0] lf);
    wait_idle();
    write_reg(CFG_FAST_GAIN, ag);
    write_reg(CFG_SLOW_GAIN, st);
    write_reg(CFG_RANGE_GAIN, rg);
    write_reg(CFG_CENTER_GAIN, ce);
    write_reg(CFG_LIMIT_FACTOR, lf);
    // unmapped indexes must leave the registers alone
    for (int i = int'(CFG_LIMIT_FACTOR) + 1; i < (1 << CFG_IDX_W); i++) begin
      write_reg(CFG_IDX_W'(i), CFG_DATA_W'($urandom));
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_setting();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      default: return CFG_DATA_W'($urandom);
    endcase
  endfunction

  task automatic load_random_regs();
    load_regs(pick_setting(), pick_setting(), pick_setting(), pick_setting(), pick_setting());
  endtask

  // runs of readings scattered around a level, with outliers, extremes and restarts
  task automatic run_phase(input int n_items);
    logic [OBS_W-1:0] level;
    logic [OBS_W-1:0] obs;
    logic [OBS_W-1:0] jitter;
    logic             rs;
    int               spread;
    int               run_len;
    int               roll;
    int               sent;
    sent = 0;
    while (sent < n_items) begin
      level   = $urandom;
      spread  = 1 << $urandom_range(0, 20);
      run_len = $urandom_range(3, 40);
      rs      = ($urandom_range(0, 2) == 0);
      for (int j = 0; j < run_len && sent < n_items; j++) begin
        roll   = $urandom_range(0, 99);
        jitter = OBS_W'($urandom_range(0, spread)) - OBS_W'(spread / 2);
        if (roll < 78) begin
          obs = level + jitter;
        end else if (roll < 88) begin
          obs = $urandom;
        end else if (roll < 94) begin
          obs = roll[0] ? '1 : '0;
        end else begin
          obs = level;
        end
        send_obs(obs, rs);
        rs = ($urandom_range(0, 49) == 0);
        sent++;
      end
    end
  endtask

  initial begin
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.observation <= '0;
    in_ch.restart     <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_idx           <= '0;
    cfg_wdata         <= '0;
    set_idling(9, 82);
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: seeding, restarts, extreme steps, steady readings and an outlier
    send_obs(32'h0000_0000, 1'b1);
    send_obs(32'hFFFF_FFFF, 1'b0);
    send_obs(32'hFFFF_FFFF, 1'b0);
    send_obs(32'h0000_0000, 1'b0);
    send_obs(32'hFFFF_FFFF, 1'b1);
    send_obs(32'h0000_0000, 1'b0);
    send_obs(32'h0000_0001, 1'b0);
    send_obs(32'h8000_0000, 1'b1);
    send_obs(32'h7FFF_FFFF, 1'b0);
    send_obs(32'd1000, 1'b1);
    send_obs(32'd1010, 1'b0);
    send_obs(32'd990, 1'b0);
    send_obs(32'd1005, 1'b0);
    send_obs(32'd1002, 1'b0);
    send_obs(32'd5000, 1'b0);
    send_obs(32'd1001, 1'b0);
    send_obs(32'd1001, 1'b0);
    send_obs(32'hAAAA_5555, 1'b0);
    send_obs(32'h5555_AAAA, 1'b0);

    load_regs('0, '0, '0, '0, '0);
    send_obs(32'd77, 1'b1);
    send_obs(32'd80, 1'b0);
    send_obs(32'd80, 1'b0);
    run_phase(120);
    load_regs('1, '1, '1, '1, '1);
    run_phase(120);

    set_idling(82, 9);
    load_regs(FAST_GAIN_RST, SLOW_GAIN_RST, RANGE_GAIN_RST, CENTER_GAIN_RST,
              LIMIT_FACTOR_RST);
    run_phase(120);
    load_random_regs();
    run_phase(120);

    set_idling(0, 0);
    load_random_regs();
    -> hold_off_ev;
    run_phase(150);
    load_random_regs();
    run_phase(150);

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
